/* src/rc4_pkg.sv */
// Shared types, constants and the control store for the RC4 stream cipher.
`timescale 1ns / 1ps
`default_nettype none

package rc4_pkg;

	localparam int unsigned RC4_MAX_KEY = 256;
	localparam int unsigned PERM_DEPTH  = 256;
	localparam int unsigned CNT_W       = 9;
	localparam int unsigned PC_W        = 4;

	// control store addresses
	localparam logic [PC_W-1:0] STEP_D0 = 4'd0;
	localparam logic [PC_W-1:0] STEP_D1 = 4'd1;
	localparam logic [PC_W-1:0] STEP_D2 = 4'd2;
	localparam logic [PC_W-1:0] STEP_D3 = 4'd3;
	localparam logic [PC_W-1:0] STEP_D4 = 4'd4;
	localparam logic [PC_W-1:0] STEP_D5 = 4'd5;
	localparam logic [PC_W-1:0] STEP_K0 = 4'd6;
	localparam logic [PC_W-1:0] STEP_K1 = 4'd7;
	localparam logic [PC_W-1:0] STEP_K2 = 4'd8;
	localparam logic [PC_W-1:0] STEP_K3 = 4'd9;
	localparam logic [PC_W-1:0] STEP_K4 = 4'd10;

	// read address select
	localparam logic [1:0] RA_I_INC = 2'd0;
	localparam logic [1:0] RA_J_NEW = 2'd1;
	localparam logic [1:0] RA_SUM   = 2'd2;
	localparam logic [1:0] RA_N     = 2'd3;

	// write address select
	localparam logic [1:0] WA_I = 2'd0;
	localparam logic [1:0] WA_J = 2'd1;
	localparam logic [1:0] WA_N = 2'd2;

	// write data select
	localparam logic WD_RD = 1'b0;
	localparam logic WD_A  = 1'b1;

	// side actions
	localparam logic [1:0] ACT_NONE = 2'd0;
	localparam logic [1:0] ACT_INIT = 2'd1;
	localparam logic [1:0] ACT_ADV  = 2'd2;

	// sequencing
	localparam logic [1:0] NXT_SEQ  = 2'd0;
	localparam logic [1:0] NXT_OUT  = 2'd1;
	localparam logic [1:0] NXT_LOOP = 2'd2;

	typedef struct packed {
		logic [1:0]      ra_sel;
		logic            wr_en;
		logic [1:0]      wa_sel;
		logic            wd_sel;
		logic            ld_i;
		logic            ld_j;
		logic            ld_a;
		logic            ld_b;
		logic            key_add;
		logic [1:0]      act;
		logic [1:0]      nxt;
		logic [PC_W-1:0] tgt;
	} ucode_t;

	typedef struct packed {
		logic       clear;
		logic       we;
		logic [7:0] waddr;
		logic [7:0] wdata;
		logic [7:0] raddr;
	} perm_req_t;

	function automatic ucode_t rc4_ucode(input logic [PC_W-1:0] pc);
		ucode_t u;
		u = '0;
		u.nxt = NXT_SEQ;
		case (pc)
			// data byte: i += 1, fetch S[i]
			STEP_D0: begin
				u.ra_sel = RA_I_INC;
				u.ld_i = 1'b1;
			end
			// j += S[i], fetch S[j]
			STEP_D1: begin
				u.ra_sel = RA_J_NEW;
				u.ld_a = 1'b1;
				u.ld_j = 1'b1;
			end
			STEP_D2: begin
				u.ld_b = 1'b1;
				u.wr_en = 1'b1;
				u.wa_sel = WA_I;
				u.wd_sel = WD_RD;
			end
			STEP_D3: begin
				u.wr_en = 1'b1;
				u.wa_sel = WA_J;
				u.wd_sel = WD_A;
			end
			STEP_D4: begin
				u.ra_sel = RA_SUM;
			end
			// hold the keystream read until the output register frees up
			STEP_D5: begin
				u.ra_sel = RA_SUM;
				u.nxt = NXT_OUT;
			end
			STEP_K0: begin
				u.act = ACT_INIT;
			end
			STEP_K1: begin
				u.ra_sel = RA_N;
			end
			STEP_K2: begin
				u.ra_sel = RA_J_NEW;
				u.ld_a = 1'b1;
				u.ld_j = 1'b1;
				u.key_add = 1'b1;
			end
			STEP_K3: begin
				u.wr_en = 1'b1;
				u.wa_sel = WA_N;
				u.wd_sel = WD_RD;
			end
			STEP_K4: begin
				u.wr_en = 1'b1;
				u.wa_sel = WA_J;
				u.wd_sel = WD_A;
				u.act = ACT_ADV;
				u.nxt = NXT_LOOP;
				u.tgt = STEP_K1;
			end
			default: begin
				u = '0;
			end
		endcase
		return u;
	endfunction

endpackage

`default_nettype wire

/* src/rc4_if.sv */
// Handshake channels for the RC4 input items and output results.
`timescale 1ns / 1ps
`default_nettype none

interface rc4_item_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] byte_value;
	logic       key_last;

	modport source (output valid, output mode, output byte_value, output key_last,
		input ready);
	modport sink (input valid, input mode, input byte_value, input key_last,
		output ready);
endinterface

interface rc4_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;

	modport source (output valid, output out_byte, input ready);
	modport sink (input valid, input out_byte, output ready);
endinterface

`default_nettype wire

/* src/rc4_perm_ram.sv */
// Permutation memory with per-entry valid bits; an invalid entry reads as its own index.
`timescale 1ns / 1ps
`default_nettype none

module rc4_perm_ram (
	input  logic              clk,
	input  logic              arst_n,
	input  rc4_pkg::perm_req_t req,
	output logic [7:0]        rdata
);
	import rc4_pkg::*;

	logic [7:0]            mem_q [PERM_DEPTH];
	logic [PERM_DEPTH-1:0] valid_q;
	logic [7:0]            rd_q;
	logic [7:0]            ra_q;
	logic                  rv_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		rd_q <= mem_q[req.raddr];
		ra_q <= req.raddr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rv_q    <= 1'b0;
		end else begin
			// clear drops the whole table back to identity
			if (req.clear) begin
				valid_q <= '0;
			end else if (req.we) begin
				valid_q[req.waddr] <= 1'b1;
			end
			rv_q <= valid_q[req.raddr];
		end
	end

	assign rdata = rv_q ? rd_q : ra_q;

`ifndef SYNTH
	a_clear_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		req.clear |-> !req.we)
		else $error("perm ram: clear and write in the same cycle");
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		req.clear |=> (valid_q == '0))
		else $error("perm ram: valid bits left after clear");
	a_write_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(req.we && !req.clear) |=> valid_q[$past(req.waddr)])
		else $error("perm ram: written entry not marked valid");
`endif

endmodule

`default_nettype wire

/* src/rc4_stream_cipher.sv */
// RC4 stream cipher top level: microcoded sequencer, key store and output register.
//
//   channel  | role   | payload                        | per transaction
//   ---------+--------+--------------------------------+----------------------------
//   item     | sink   | mode, byte_value, key_last     | key byte or data byte
//   result   | source | out_byte                       | one per data byte
//
// A data byte keeps the sequencer busy for six control steps (each one read or
// write on the permutation memory, which has separate read and write ports); no
// item is accepted meanwhile. A key byte without last leaves the sequencer idle.
// A last key byte runs the key schedule: an init step, then K1 to K4 for each of the 256 entries.
// Reset leaves the permutation as identity through its valid bits; no clearing pass.
// A waiting result blocks acceptance only by stalling the sequencer, which only stalls in its
// final data step while the output register is full and result.ready is low.
`timescale 1ns / 1ps
`default_nettype none

module rc4_stream_cipher #(
	parameter int unsigned MAX_KEY = rc4_pkg::RC4_MAX_KEY
) (
	input  logic                clk,
	input  logic                arst_n,
	rc4_item_if.sink            item,
	rc4_result_if.source        result
);
	import rc4_pkg::*;

	localparam int unsigned KW = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;

	logic                  busy_q;
	logic [PC_W-1:0]       pc_q;
	logic [7:0]            i_q;
	logic [7:0]            j_q;
	logic [7:0]            a_q;
	logic [7:0]            b_q;
	logic [7:0]            n_q;
	logic [KW-1:0]         kpos_q;
	logic [CNT_W-1:0]      len_q;
	logic [CNT_W-1:0]      count_q;
	logic [7:0]            val_q;
	logic [7:0]            kd_q;
	logic                  out_valid_q;
	logic [7:0]            out_byte_q;
	logic [7:0]            key_mem_q [MAX_KEY];

	ucode_t                uc;
	perm_req_t             preq;
	logic [7:0]            rd;
	logic [7:0]            j_new;
	logic                  accept;
	logic                  key_we;
	logic                  load_out;
	logic                  sched_last;
	logic [CNT_W-1:0]      kpos_inc;

	assign accept = item.valid && item.ready;
	assign key_we = accept && !item.mode && (count_q < CNT_W'(MAX_KEY));
	assign uc = busy_q ? rc4_ucode(pc_q) : ucode_t'('0);
	assign load_out = busy_q && (uc.nxt == NXT_OUT) && (!out_valid_q || result.ready);
	assign sched_last = (uc.act == ACT_ADV) && (n_q == 8'hFF);
	assign kpos_inc = CNT_W'(kpos_q) + CNT_W'(1);
	assign j_new = j_q + rd + (uc.key_add ? kd_q : 8'd0);

	assign item.ready = !busy_q;
	assign result.valid = out_valid_q;
	assign result.out_byte = out_byte_q;

	always_comb begin
		preq = '0;
		preq.clear = (uc.act == ACT_INIT);
		preq.we = uc.wr_en;
		case (uc.ra_sel)
			RA_I_INC: preq.raddr = i_q + 8'd1;
			RA_J_NEW: preq.raddr = j_new;
			RA_SUM:   preq.raddr = a_q + b_q;
			RA_N:     preq.raddr = n_q;
			default:  preq.raddr = n_q;
		endcase
		case (uc.wa_sel)
			WA_I:    preq.waddr = i_q;
			WA_J:    preq.waddr = j_q;
			WA_N:    preq.waddr = n_q;
			default: preq.waddr = n_q;
		endcase
		preq.wdata = (uc.wd_sel == WD_A) ? a_q : rd;
	end

	rc4_perm_ram u_perm (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (preq),
		.rdata (rd)
	);

	// key store
	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem_q[count_q[KW-1:0]] <= item.byte_value;
		end
		kd_q <= key_mem_q[kpos_q];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= STEP_D0;
		end else if (accept) begin
			if (item.mode) begin
				busy_q <= 1'b1;
				pc_q   <= STEP_D0;
			end else if (item.key_last) begin
				busy_q <= 1'b1;
				pc_q   <= STEP_K0;
			end
		end else if (busy_q) begin
			case (uc.nxt)
				NXT_SEQ: pc_q <= pc_q + PC_W'(1);
				NXT_OUT: begin
					if (load_out) begin
						busy_q <= 1'b0;
					end
				end
				NXT_LOOP: begin
					if (n_q == 8'hFF) begin
						busy_q <= 1'b0;
					end else begin
						pc_q <= uc.tgt;
					end
				end
				default: busy_q <= 1'b0;
			endcase
		end
	end

	// generator indices and key count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q     <= '0;
			j_q     <= '0;
			count_q <= '0;
		end else begin
			if (uc.ld_i) begin
				i_q <= i_q + 8'd1;
			end else if (sched_last) begin
				i_q <= '0;
			end
			if (uc.ld_j) begin
				j_q <= j_new;
			end else if (uc.act == ACT_INIT || sched_last) begin
				j_q <= '0;
			end
			if (key_we) begin
				count_q <= count_q + CNT_W'(1);
			end else if (uc.act == ACT_INIT) begin
				count_q <= '0;
			end
		end
	end

	// datapath scratch registers
	always_ff @(posedge clk) begin
		if (accept) begin
			val_q <= item.byte_value;
		end
		if (uc.ld_a) begin
			a_q <= rd;
		end
		if (uc.ld_b) begin
			b_q <= rd;
		end
		if (uc.act == ACT_INIT) begin
			len_q  <= count_q;
			n_q    <= '0;
			kpos_q <= '0;
		end else if (uc.act == ACT_ADV) begin
			n_q <= n_q + 8'd1;
			// wrap the key position at the loaded key length
			if (kpos_inc == len_q) begin
				kpos_q <= '0;
			end else begin
				kpos_q <= kpos_inc[KW-1:0];
			end
		end
		if (load_out) begin
			out_byte_q <= val_q ^ rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_KEY))
		else $error("rc4: key count beyond maximum");
	a_data_start: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready && item.mode) |=> (busy_q && pc_q == STEP_D0))
		else $error("rc4: data transaction did not start the generator");
	a_sched_end: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && uc.nxt == NXT_LOOP && n_q == 8'hFF)
		|=> (!busy_q && i_q == '0 && j_q == '0 && count_q == '0))
		else $error("rc4: key schedule did not end cleanly");
`endif

endmodule

`default_nettype wire
